// ===== rtl/buzzer_beep_pattern_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// Buzzer beep pattern sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef BUZZER_BEEP_PATTERN_SEQUENCER_MACROS_SVH
`define BUZZER_BEEP_PATTERN_SEQUENCER_MACROS_SVH

// Property must hold at every edge out of reset.
`define BBPS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bbps assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BBPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bbps assertion failed");

`endif

// ===== rtl/bbps_pkg.sv =====
// ----------------------------------------------------------------------------
// Buzzer beep pattern sequencer package
// Item kinds, pattern register layout and fixed constants.
// ----------------------------------------------------------------------------
package bbps_pkg;

  localparam int unsigned NUM_PATTERNS = 6;
  localparam int unsigned PAT_W        = 48;
  localparam int unsigned CNT_W        = 16;
  localparam int unsigned IDX_W        = 3;

  localparam logic [IDX_W-1:0] PAT_KEY = 3'd0;

  localparam logic [CNT_W-1:0] TIMER_IDLE    = 16'hFFFF;
  localparam logic [CNT_W-1:0] COUNT_ENDLESS = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2
  } kind_e;

  // count 47:32, off ticks 31:16, on ticks 15:0
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] off_ticks;
    logic [CNT_W-1:0] on_ticks;
  } pattern_t;

endpackage

// ===== rtl/buzzer_beep_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// Buzzer beep pattern sequencer
// Six programmable on/off/repeat beep patterns driven by tick, start and stop
// requests; one status result per request.
// ----------------------------------------------------------------------------
// Each request (tick, start or stop) is taken on a handshake and its result,
// the buzzer level and busy flag after the request, appears on the master
// side on the next clock. A new request is taken every cycle as long as the
// result register is empty or being drained; the figure is set by the single
// registered update of the sequencer state and the one-deep result register.
// Pattern registers are written through the cfg port and are read live on
// every phase reload of the running pattern.
`include "buzzer_beep_pattern_sequencer_macros.svh"

module buzzer_beep_pattern_sequencer
  import bbps_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [IDX_W-1:0]     cfg_idx_i,
  input  logic [PAT_W-1:0]     cfg_data_i,

  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [2:0] pattern_sel, [7:3] zero
  input  logic [1:0]           s_axis_tuser,   // [1:0] kind

  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata    // [0] buzzer_drive, [1] busy_res, [7:2] zero
);

  pattern_t         pat_q [NUM_PATTERNS];

  logic             active_q, active_d;
  logic             phase_off_q, phase_off_d;
  logic [IDX_W-1:0] pattern_id_q, pattern_id_d;
  logic [CNT_W-1:0] on_left_q, on_left_d;
  logic [CNT_W-1:0] off_left_q, off_left_d;
  logic [CNT_W-1:0] beeps_left_q, beeps_left_d;
  logic             drive_q, drive_d;

  logic             out_valid_q;
  logic [1:0]       out_data_q;

  logic             in_acc;
  logic [IDX_W-1:0] sel;
  logic [IDX_W-1:0] rd_addr;
  pattern_t         rd_pat;
  logic [CNT_W-1:0] beeps_dec;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign sel           = s_axis_tdata[IDX_W-1:0];

  // start reads the selected pattern, tick reloads from the running one
  assign rd_addr = (s_axis_tuser == KIND_START) ? sel : pattern_id_q;

  always_comb begin
    if (rd_addr < IDX_W'(NUM_PATTERNS)) begin
      rd_pat = pat_q[rd_addr];
    end else begin
      rd_pat = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        pat_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < IDX_W'(NUM_PATTERNS))) begin
      pat_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    active_d     = active_q;
    phase_off_d  = phase_off_q;
    pattern_id_d = pattern_id_q;
    on_left_d    = on_left_q;
    off_left_d   = off_left_q;
    beeps_left_d = beeps_left_q;
    drive_d      = drive_q;
    beeps_dec    = beeps_left_q;

    if (in_acc) begin
      case (s_axis_tuser)
        KIND_TICK: begin
          if (active_q) begin
            if (!phase_off_q) begin
              if (on_left_q == '0) begin
                drive_d   = 1'b0;
                on_left_d = TIMER_IDLE;
                if (beeps_left_q != COUNT_ENDLESS && beeps_left_q != '0) begin
                  beeps_dec = beeps_left_q - CNT_W'(1);
                end
                beeps_left_d = beeps_dec;
                if (beeps_dec != '0) begin
                  off_left_d  = rd_pat.off_ticks;
                  phase_off_d = 1'b1;
                end else begin
                  active_d    = 1'b0;
                  phase_off_d = 1'b0;
                  off_left_d  = TIMER_IDLE;
                end
              end else begin
                on_left_d = on_left_q - CNT_W'(1);
              end
            end else begin
              if (off_left_q == '0) begin
                off_left_d = TIMER_IDLE;
                if (beeps_left_q != '0) begin
                  drive_d     = 1'b1;
                  phase_off_d = 1'b0;
                  on_left_d   = rd_pat.on_ticks;
                end else begin
                  active_d    = 1'b0;
                  phase_off_d = 1'b0;
                  on_left_d   = TIMER_IDLE;
                end
              end else begin
                off_left_d = off_left_q - CNT_W'(1);
              end
            end
          end
        end
        KIND_START: begin
          // key click never interrupts a running pattern
          if ((sel < IDX_W'(NUM_PATTERNS)) && !(active_q && sel == PAT_KEY)) begin
            active_d     = 1'b1;
            pattern_id_d = sel;
            phase_off_d  = 1'b0;
            off_left_d   = TIMER_IDLE;
            on_left_d    = rd_pat.on_ticks;
            beeps_left_d = rd_pat.count;
            drive_d      = 1'b1;
          end
        end
        KIND_STOP: begin
          active_d     = 1'b0;
          phase_off_d  = 1'b0;
          on_left_d    = TIMER_IDLE;
          off_left_d   = TIMER_IDLE;
          beeps_left_d = COUNT_ENDLESS;
          drive_d      = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      phase_off_q  <= 1'b0;
      pattern_id_q <= '0;
      on_left_q    <= TIMER_IDLE;
      off_left_q   <= TIMER_IDLE;
      beeps_left_q <= '0;
      drive_q      <= 1'b0;
    end else begin
      active_q     <= active_d;
      phase_off_q  <= phase_off_d;
      pattern_id_q <= pattern_id_d;
      on_left_q    <= on_left_d;
      off_left_q   <= off_left_d;
      beeps_left_q <= beeps_left_d;
      drive_q      <= drive_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= {active_d, drive_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_data_q};

  `BBPS_ASSERT(a_drive_tracks_phase, drive_q == (active_q && !phase_off_q))
  `BBPS_ASSERT(a_idle_timers, !active_q |-> (on_left_q == TIMER_IDLE && off_left_q == TIMER_IDLE))
  `BBPS_ASSERT(a_off_phase_on_idle, phase_off_q |-> (active_q && on_left_q == TIMER_IDLE))
  `BBPS_ASSERT_NEXT(a_stop_idles, in_acc && s_axis_tuser == KIND_STOP, !active_q && !drive_q)

endmodule

// ===== sim/tb_buzzer_beep_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// Buzzer beep pattern sequencer testbench
// Feeds tick, start and stop requests with random gaps on both stream sides.
// A behavioral copy of the sequencer predicts the buzzer level and busy flag
// for every accepted request. Each result is checked in order against that
// prediction. Pattern registers are reprogrammed between phases while idle.
// ----------------------------------------------------------------------------
module tb_buzzer_beep_pattern_sequencer;
  import bbps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // kind code the block has to ignore
  localparam logic [1:0] KIND_RSVD = 2'd3;

  // pattern selects and register indexes share one numbering
  typedef enum logic [IDX_W-1:0] {
    SEL_KEY      = 3'd0,
    SEL_POWER    = 3'd1,
    SEL_SHUTDOWN = 3'd2,
    SEL_CALIB    = 3'd3,
    SEL_UNCAL    = 3'd4,
    SEL_ACTION   = 3'd5,
    SEL_BAD6     = 3'd6,
    SEL_BAD7     = 3'd7
  } pat_sel_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] sel;
  } buzz_req_t;

  typedef struct packed {
    logic drive;
    logic busy;
  } buzz_status_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i = '0;
  logic [PAT_W-1:0] cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;  // [2:0] pattern_sel, [7:3] zero
  logic [1:0]       s_axis_tuser = '0;  // [1:0] kind
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;       // [0] buzzer_drive, [1] busy_res, [7:2] zero

  buzzer_beep_pattern_sequencer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  buzz_req_t    req_q[$];
  buzz_status_t status_q[$];
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           err_cnt = 0;
  logic         req_taken = 1'b0;

  // shadow of the sequencer; entries 6 and 7 stay zero
  pattern_t         pat_regs [8] = '{default: '0};
  logic             sq_active = 1'b0;
  logic             sq_phase_off = 1'b0;
  logic [IDX_W-1:0] sq_pid = '0;
  logic [CNT_W-1:0] sq_on_left = TIMER_IDLE;
  logic [CNT_W-1:0] sq_off_left = TIMER_IDLE;
  logic [CNT_W-1:0] sq_beeps_left = '0;
  logic             sq_drive = 1'b0;

  function automatic void sequencer_go_idle();
    sq_active    = 1'b0;
    sq_phase_off = 1'b0;
    sq_on_left   = TIMER_IDLE;
    sq_off_left  = TIMER_IDLE;
  endfunction

  function automatic buzz_status_t advance_sequencer(buzz_req_t req);
    buzz_status_t st;
    if (req.kind == KIND_TICK) begin
      if (sq_active && !sq_phase_off) begin
        if (sq_on_left == '0) begin
          sq_drive   = 1'b0;
          sq_on_left = TIMER_IDLE;
          if (sq_beeps_left != COUNT_ENDLESS && sq_beeps_left != '0)
            sq_beeps_left = sq_beeps_left - 1'b1;
          if (sq_beeps_left != '0) begin
            sq_off_left  = pat_regs[sq_pid].off_ticks;
            sq_phase_off = 1'b1;
          end else begin
            sequencer_go_idle();
          end
        end else begin
          sq_on_left = sq_on_left - 1'b1;
        end
      end else if (sq_active) begin
        if (sq_off_left == '0) begin
          sq_off_left = TIMER_IDLE;
          if (sq_beeps_left != '0) begin
            sq_drive     = 1'b1;
            sq_phase_off = 1'b0;
            sq_on_left   = pat_regs[sq_pid].on_ticks;
          end else begin
            sequencer_go_idle();
          end
        end else begin
          sq_off_left = sq_off_left - 1'b1;
        end
      end
    end else if (req.kind == KIND_START) begin
      // key click is dropped while busy, unknown selects always
      if (req.sel < NUM_PATTERNS && !(sq_active && req.sel == PAT_KEY)) begin
        sq_active     = 1'b1;
        sq_pid        = req.sel;
        sq_phase_off  = 1'b0;
        sq_off_left   = TIMER_IDLE;
        sq_on_left    = pat_regs[req.sel].on_ticks;
        sq_beeps_left = pat_regs[req.sel].count;
        sq_drive      = 1'b1;
      end
    end else if (req.kind == KIND_STOP) begin
      sequencer_go_idle();
      sq_beeps_left = COUNT_ENDLESS;
      sq_drive      = 1'b0;
    end
    st.drive = sq_drive;
    st.busy  = sq_active;
    return st;
  endfunction

  // request driver
  always @(negedge clk_i) begin : drive_req
    buzz_req_t nxt;
    if (!s_axis_tvalid || req_taken) begin
      if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = req_q.pop_front();
        s_axis_tdata  <= {5'b0, nxt.sel};
        s_axis_tuser  <= nxt.kind;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // predict on accepted requests, check accepted results
  always @(posedge clk_i) begin : check_res
    buzz_req_t    req;
    buzz_status_t want;
    buzz_status_t got;
    req_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        req.kind = s_axis_tuser;
        req.sel  = s_axis_tdata[IDX_W-1:0];
        status_q.push_back(advance_sequencer(req));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.drive = m_axis_tdata[0];
        got.busy  = m_axis_tdata[1];
        if (status_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: unexpected result drive=%0b busy=%0b", $realtime,
                     got.drive, got.busy);
        end else begin
          want = status_q.pop_front();
          if (got != want) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("%0t: mismatch drive exp %0b got %0b, busy exp %0b got %0b",
                       $realtime, want.drive, got.drive, want.busy, got.busy);
          end
        end
      end
    end
  end

  task automatic push_req(logic [1:0] kind, logic [IDX_W-1:0] sel);
    buzz_req_t r;
    r.kind = kind;
    r.sel  = sel;
    req_q.push_back(r);
  endtask

  task automatic write_pattern(pat_sel_e idx, pattern_t val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    pat_regs[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || s_axis_tvalid || status_q.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (2) @(posedge clk_i);
  endtask

  function automatic pattern_t short_pattern();
    pattern_t p;
    int       pick;
    p.on_ticks  = CNT_W'($urandom_range(0, 3));
    p.off_ticks = CNT_W'($urandom_range(0, 3));
    pick = $urandom_range(0, 9);
    if (pick < 7)
      p.count = CNT_W'($urandom_range(0, 4));
    else if (pick < 9)
      p.count = COUNT_ENDLESS;
    else
      p.count = CNT_W'($urandom_range(5, 8));
    return p;
  endfunction

  // noise: reserved kind or an unknown pattern select
  task automatic push_noise();
    if ($urandom_range(0, 1) == 0)
      push_req(KIND_RSVD, IDX_W'($urandom_range(0, 7)));
    else
      push_req(KIND_START, IDX_W'($urandom_range(SEL_BAD6, SEL_BAD7)));
  endtask

  // start a pattern and tick it along, with stops, restarts and noise mixed in
  task automatic push_beep_run(ref int taken);
    int nticks;
    int pick;
    push_req(KIND_START, IDX_W'($urandom_range(SEL_KEY, SEL_ACTION)));
    taken++;
    nticks = $urandom_range(0, 24);
    repeat (nticks) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        push_req(KIND_STOP, IDX_W'($urandom_range(0, 7)));
        taken++;
      end else if (pick < 7) begin
        push_req(KIND_START, IDX_W'($urandom_range(SEL_KEY, SEL_ACTION)));
        taken++;
      end else if (pick < 10) begin
        push_noise();
      end else begin
        push_req(KIND_TICK, IDX_W'($urandom_range(0, 7)));
        taken++;
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      push_req(KIND_STOP, IDX_W'($urandom_range(0, 7)));
      taken++;
    end
  endtask

  initial begin : stimulus
    int       taken;
    pattern_t p;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 29;
    recv_idle_pct = 67;
    p = '{count: 16'd2, off_ticks: 16'd1, on_ticks: 16'd1};
    write_pattern(SEL_KEY, p);
    p = '{count: COUNT_ENDLESS, off_ticks: 16'd0, on_ticks: 16'd0};
    write_pattern(SEL_POWER, p);
    write_pattern(SEL_SHUTDOWN, '1);
    write_pattern(SEL_CALIB, '0);
    p = '{count: 16'd1, off_ticks: 16'd5, on_ticks: 16'd2};
    write_pattern(SEL_UNCAL, p);
    p = '{count: 16'd3, off_ticks: 16'd2, on_ticks: 16'd0};
    write_pattern(SEL_ACTION, p);

    // idle corner cases, then key click and its busy lockout
    push_req(KIND_TICK, SEL_KEY);
    push_req(KIND_STOP, SEL_KEY);
    push_req(KIND_RSVD, SEL_BAD7);
    push_req(KIND_START, SEL_BAD7);
    push_req(KIND_START, SEL_BAD6);
    push_req(KIND_START, SEL_KEY);
    push_req(KIND_START, SEL_KEY);
    repeat (3) push_req(KIND_TICK, SEL_KEY);
    // restart while busy, then endless repeat
    push_req(KIND_START, SEL_ACTION);
    repeat (4) push_req(KIND_TICK, SEL_KEY);
    push_req(KIND_START, SEL_POWER);
    repeat (5) push_req(KIND_TICK, SEL_KEY);
    push_req(KIND_STOP, SEL_KEY);
    // zero count gives one beep; all-ones pattern then noise while busy
    push_req(KIND_START, SEL_CALIB);
    push_req(KIND_TICK, SEL_KEY);
    push_req(KIND_START, SEL_SHUTDOWN);
    push_req(KIND_TICK, SEL_KEY);
    push_req(KIND_RSVD, SEL_ACTION);
    push_req(KIND_START, SEL_BAD6);
    push_req(KIND_STOP, SEL_KEY);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 29 : (ph < 4) ? 67 : 0;
      recv_idle_pct = (ph < 2) ? 67 : (ph < 4) ? 29 : 0;
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        if (ph == 1)
          p = '1;
        else if (ph == 2)
          p = '0;
        else if (ph == 5 && i == SEL_UNCAL)
          p = {CNT_W'($urandom), CNT_W'($urandom), CNT_W'($urandom)};
        else
          p = short_pattern();
        write_pattern(pat_sel_e'(i), p);
      end
      taken = 0;
      while (taken < 70) begin
        if ($urandom_range(0, 99) < 8)
          push_noise();
        else
          push_beep_run(taken);
      end
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    if (err_cnt == 0 && status_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin : run_limit
    #400us;
    $display("TB_ERROR");
    $finish;
  end

endmodule
